[rtl/avr8alu_pkg.sv]
// ---------------------------------------------------------------------------
// avr8alu_pkg
// Shared types, constants and decode functions of the AVR ALU execute block.
// ---------------------------------------------------------------------------
package avr8alu_pkg;

   localparam int WORD_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int REG_COUNT   = 32;
   localparam int REG_IDX_W   = 5;
   localparam int BANK_DEPTH  = REG_COUNT / 2;
   localparam int BANK_ADDR_W = REG_IDX_W - 1;
   localparam int KIND_W      = 2;
   localparam int RSP_DATA_W  = 32;
   localparam int RSP_USER_W  = 3;

   // register write kinds
   localparam logic [KIND_W-1:0] WK_NONE = 2'd0;
   localparam logic [KIND_W-1:0] WK_BYTE = 2'd1;
   localparam logic [KIND_W-1:0] WK_PAIR = 2'd2;

   // status register bit positions
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_N = 2;
   localparam int FLAG_V = 3;
   localparam int FLAG_S = 4;
   localparam int FLAG_H = 5;
   localparam int FLAG_T = 6;
   localparam int FLAG_I = 7;

   // opcode patterns
   localparam logic [WORD_W-1:0] MASK_RR   = 16'hFC00;
   localparam logic [WORD_W-1:0] MASK_IMM  = 16'hF000;
   localparam logic [WORD_W-1:0] MASK_WORD = 16'hFF00;
   localparam logic [WORD_W-1:0] PAT_ADC   = 16'h1C00;
   localparam logic [WORD_W-1:0] PAT_CPC   = 16'h0400;
   localparam logic [WORD_W-1:0] PAT_EOR   = 16'h2400;
   localparam logic [WORD_W-1:0] PAT_CPI   = 16'h3000;
   localparam logic [WORD_W-1:0] PAT_ORI   = 16'h6000;
   localparam logic [WORD_W-1:0] PAT_LDI   = 16'hE000;
   localparam logic [WORD_W-1:0] PAT_SBIW  = 16'h9700;
   localparam logic [WORD_W-1:0] WORD_SEI  = 16'h9478;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADC,
      OP_CPC,
      OP_EOR,
      OP_CPI,
      OP_ORI,
      OP_LDI,
      OP_SBIW,
      OP_SEI
   } op_type;

   // outcome of one executed instruction
   typedef struct packed {
      logic [KIND_W-1:0]    write_kind;
      logic [REG_IDX_W-1:0] dest_index;
      logic [WORD_W-1:0]    write_value;
      logic [BYTE_W-1:0]    status_after;
      logic                 unknown_opcode;
   } exec_result_type;

   function automatic op_type decode_op(input logic [WORD_W-1:0] w);
      op_type op;
      op = OP_NONE;
      if ((w & MASK_RR) == PAT_ADC)         op = OP_ADC;
      else if ((w & MASK_RR) == PAT_CPC)    op = OP_CPC;
      else if ((w & MASK_RR) == PAT_EOR)    op = OP_EOR;
      else if ((w & MASK_IMM) == PAT_CPI)   op = OP_CPI;
      else if ((w & MASK_IMM) == PAT_ORI)   op = OP_ORI;
      else if ((w & MASK_IMM) == PAT_LDI)   op = OP_LDI;
      else if ((w & MASK_WORD) == PAT_SBIW) op = OP_SBIW;
      else if (w == WORD_SEI)               op = OP_SEI;
      return op;
   endfunction

   // upper-half register of the immediate forms, r16 to r31
   function automatic logic [REG_IDX_W-1:0] high_reg(input logic [WORD_W-1:0] w);
      return {1'b1, w[7:4]};
   endfunction

   // low register of the SBIW pair: r24, r26, r28 or r30
   function automatic logic [REG_IDX_W-1:0] pair_low(input logic [WORD_W-1:0] w);
      return {2'b11, w[5:4], 1'b0};
   endfunction

   function automatic logic [REG_IDX_W-1:0] operand_a_index(input logic [WORD_W-1:0] w);
      logic [REG_IDX_W-1:0] idx;
      idx = w[8:4];
      case (decode_op(w)) inside
         OP_CPI, OP_ORI, OP_LDI: idx = high_reg(w);
         OP_SBIW:                idx = pair_low(w);
         default:                idx = w[8:4];
      endcase
      return idx;
   endfunction

   function automatic logic [REG_IDX_W-1:0] operand_b_index(input logic [WORD_W-1:0] w);
      logic [REG_IDX_W-1:0] idx;
      idx = {w[9], w[3:0]};
      case (decode_op(w))
         OP_SBIW: idx = {2'b11, w[5:4], 1'b1};
         default: idx = {w[9], w[3:0]};
      endcase
      return idx;
   endfunction

endpackage

[rtl/avr8alu_ram.sv]
// ---------------------------------------------------------------------------
// avr8alu_ram
// Generic RAM: one write port, two read ports, registered read data.
// ---------------------------------------------------------------------------
module avr8alu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read ports, old data on a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/avr8alu_exec.sv]
// ---------------------------------------------------------------------------
// avr8alu_exec
// Combinational execute unit: result, register write and new status flags.
// ---------------------------------------------------------------------------
module avr8alu_exec
   import avr8alu_pkg::*;
(
   input  logic [WORD_W-1:0] instruction,
   input  logic [BYTE_W-1:0] operand_a,
   input  logic [BYTE_W-1:0] operand_b,
   input  logic [BYTE_W-1:0] status,
   output exec_result_type   result
);

   op_type              op;
   logic [BYTE_W-1:0]   imm;
   logic [5:0]          word_k;
   logic                carry_in;
   logic [BYTE_W:0]     add_sum;
   logic [BYTE_W-1:0]   add_res;
   logic [BYTE_W-1:0]   sub_b;
   logic                sub_cin;
   logic [BYTE_W:0]     sub_diff;
   logic [BYTE_W-1:0]   sub_res;
   logic [BYTE_W-1:0]   logic_res;
   logic [WORD_W-1:0]   pair_old;
   logic [WORD_W-1:0]   pair_res;
   logic [BYTE_W-1:0]   s;

   assign op       = decode_op(instruction);
   assign imm      = {instruction[11:8], instruction[3:0]};
   assign word_k   = {instruction[7:6], instruction[3:0]};
   assign carry_in = status[FLAG_C];

   // adder for adc
   assign add_sum = {1'b0, operand_a} + {1'b0, operand_b} + {{BYTE_W{1'b0}}, carry_in};
   assign add_res = add_sum[BYTE_W-1:0];

   // shared subtractor for cpc and cpi
   assign sub_b    = (op == OP_CPI) ? imm : operand_b;
   assign sub_cin  = (op == OP_CPC) ? carry_in : 1'b0;
   assign sub_diff = {1'b0, operand_a} - {1'b0, sub_b} - {{BYTE_W{1'b0}}, sub_cin};
   assign sub_res  = sub_diff[BYTE_W-1:0];

   // logic unit for eor and ori
   assign logic_res = (op == OP_ORI) ? (operand_a | imm) : (operand_a ^ operand_b);

   // word subtract for sbiw, b holds the high byte of the pair
   assign pair_old = {operand_b, operand_a};
   assign pair_res = pair_old - {{(WORD_W-6){1'b0}}, word_k};

   // flag and write selection
   always_comb begin
      s                     = status;
      result.write_kind     = WK_NONE;
      result.dest_index     = '0;
      result.write_value    = '0;
      result.unknown_opcode = 1'b0;
      unique case (op)
         OP_ADC: begin
            s[FLAG_H] = (operand_a[3] & operand_b[3]) | (operand_b[3] & ~add_res[3])
                      | (~add_res[3] & operand_a[3]);
            s[FLAG_V] = (operand_a[7] & operand_b[7] & ~add_res[7])
                      | (~operand_a[7] & ~operand_b[7] & add_res[7]);
            s[FLAG_N] = add_res[7];
            s[FLAG_Z] = (add_res == '0);
            s[FLAG_C] = (operand_a[7] & operand_b[7]) | (operand_b[7] & ~add_res[7])
                      | (~add_res[7] & operand_a[7]);
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
            result.write_kind  = WK_BYTE;
            result.dest_index  = instruction[8:4];
            result.write_value = {{(WORD_W-BYTE_W){1'b0}}, add_res};
         end
         OP_CPC, OP_CPI: begin
            s[FLAG_H] = (~operand_a[3] & sub_b[3]) | (sub_b[3] & sub_res[3])
                      | (sub_res[3] & ~operand_a[3]);
            s[FLAG_V] = (operand_a[7] & ~sub_b[7] & ~sub_res[7])
                      | (~operand_a[7] & sub_b[7] & sub_res[7]);
            s[FLAG_N] = sub_res[7];
            // cpc leaves z alone on a zero result
            if (sub_res != '0) begin
               s[FLAG_Z] = 1'b0;
            end else if (op == OP_CPI) begin
               s[FLAG_Z] = 1'b1;
            end
            s[FLAG_C] = (~operand_a[7] & sub_b[7]) | (sub_b[7] & sub_res[7])
                      | (sub_res[7] & ~operand_a[7]);
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
         end
         OP_EOR, OP_ORI: begin
            s[FLAG_V] = 1'b0;
            s[FLAG_N] = logic_res[7];
            s[FLAG_Z] = (logic_res == '0);
            s[FLAG_S] = logic_res[7];
            result.write_kind  = WK_BYTE;
            result.dest_index  = (op == OP_ORI) ? high_reg(instruction) : instruction[8:4];
            result.write_value = {{(WORD_W-BYTE_W){1'b0}}, logic_res};
         end
         OP_LDI: begin
            result.write_kind  = WK_BYTE;
            result.dest_index  = high_reg(instruction);
            result.write_value = {{(WORD_W-BYTE_W){1'b0}}, imm};
         end
         OP_SBIW: begin
            s[FLAG_V] = pair_old[WORD_W-1] & ~pair_res[WORD_W-1];
            s[FLAG_N] = pair_res[WORD_W-1];
            s[FLAG_Z] = (pair_res == '0);
            s[FLAG_C] = pair_res[WORD_W-1] & ~pair_old[WORD_W-1];
            s[FLAG_S] = s[FLAG_N] ^ s[FLAG_V];
            result.write_kind  = WK_PAIR;
            result.dest_index  = pair_low(instruction);
            result.write_value = pair_res;
         end
         OP_SEI: begin
            s[FLAG_I] = 1'b1;
         end
         default: begin
            result.unknown_opcode = 1'b1;
         end
      endcase
      result.status_after = s;
   end

endmodule

[rtl/avr8alu_register_execute_top.sv]
// ---------------------------------------------------------------------------
// avr8_alu_register_execute_top
// AVR ALU execute stage with 32 x 8 register file and status register.
// ---------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   req_tdata[15:0]  instruction_word
//  rsp      out  rsp_tvalid/rsp_tready   rsp_tdata[31:0]  dest_index, write_value,
//                                                        status_after
//                                        rsp_tuser[2:0]   write_kind, unknown_opcode
//
//  one instruction per clock while rsp is not stalled; a req transfer loads the
//  execute stage, and its result is then registered in the result register behind rsp
//  register file is two 16 x 8 banks (even and odd registers) with registered
//  reads; the write of the previous instruction is forwarded from the result
//  register; per-register valid bits make the file read as zero after reset
//  reset clears valid bits, status and both stage valids; no clearing pass
//  a stalled rsp holds the execute stage; req_tready drops only when both
//  stages are full and rsp is not taken
// ---------------------------------------------------------------------------
module avr8_alu_register_execute_top
   import avr8alu_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [WORD_W-1:0]     req_tdata,   // [15:0] instruction_word
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [4:0] dest_index, [20:5] write_value,
                                              // [28:21] status_after, [31:29] zero
   output logic [RSP_USER_W-1:0] rsp_tuser    // [1:0] write_kind, [2] unknown_opcode
);

   logic                 req_xfer;
   logic                 ex_go;
   logic                 ex_valid_ff, ex_valid_in;
   logic [WORD_W-1:0]    ex_instr_ff;
   logic [REG_IDX_W-1:0] idx_a_ff;
   logic [REG_IDX_W-1:0] idx_b_ff;
   logic                 fwd_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   exec_result_type      rsp_ff;
   exec_result_type      ex_result;
   logic [BYTE_W-1:0]    status_ff;
   logic [REG_COUNT-1:0] reg_valid_ff, reg_valid_in;
   logic [REG_IDX_W-1:0] rd_idx_a;
   logic [REG_IDX_W-1:0] rd_idx_b;
   logic [BYTE_W-1:0]    even_a, even_b, odd_a, odd_b;
   logic [BYTE_W-1:0]    operand_a, operand_b;
   logic                 even_wr_en, odd_wr_en;
   logic [BANK_ADDR_W-1:0] bank_wr_addr;
   logic [BYTE_W-1:0]    even_wr_data, odd_wr_data;

   // handshakes
   assign ex_go      = ex_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~ex_valid_ff | ex_go;
   assign req_xfer   = req_tvalid & req_tready;

   assign rd_idx_a = operand_a_index(req_tdata);
   assign rd_idx_b = operand_b_index(req_tdata);

   // read stage registers
   assign ex_valid_in = req_xfer | (ex_valid_ff & ~ex_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
         if (req_xfer) begin
            fwd_ff <= ex_go;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ex_instr_ff <= req_tdata;
         idx_a_ff    <= rd_idx_a;
         idx_b_ff    <= rd_idx_b;
      end
   end

   // register file banks
   always_comb begin
      even_wr_en   = 1'b0;
      odd_wr_en    = 1'b0;
      bank_wr_addr = ex_result.dest_index[REG_IDX_W-1:1];
      even_wr_data = ex_result.write_value[BYTE_W-1:0];
      odd_wr_data  = ex_result.write_value[BYTE_W-1:0];
      if (ex_go) begin
         case (ex_result.write_kind)
            WK_BYTE: begin
               even_wr_en = ~ex_result.dest_index[0];
               odd_wr_en  = ex_result.dest_index[0];
            end
            WK_PAIR: begin
               even_wr_en  = 1'b1;
               odd_wr_en   = 1'b1;
               odd_wr_data = ex_result.write_value[WORD_W-1:BYTE_W];
            end
            default: begin
               even_wr_en = 1'b0;
               odd_wr_en  = 1'b0;
            end
         endcase
      end
   end

   avr8alu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_even_bank (
      .clock     (clock),
      .wr_en     (even_wr_en),
      .wr_addr   (bank_wr_addr),
      .wr_data   (even_wr_data),
      .rd_en     (req_xfer),
      .rd_addr_a (rd_idx_a[REG_IDX_W-1:1]),
      .rd_addr_b (rd_idx_b[REG_IDX_W-1:1]),
      .rd_data_a (even_a),
      .rd_data_b (even_b)
   );

   avr8alu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BANK_DEPTH)
   ) u_odd_bank (
      .clock     (clock),
      .wr_en     (odd_wr_en),
      .wr_addr   (bank_wr_addr),
      .wr_data   (odd_wr_data),
      .rd_en     (req_xfer),
      .rd_addr_a (rd_idx_a[REG_IDX_W-1:1]),
      .rd_addr_b (rd_idx_b[REG_IDX_W-1:1]),
      .rd_data_a (odd_a),
      .rd_data_b (odd_b)
   );

   // operand select: forwarded write, then bank data, zero if never written
   function automatic logic [BYTE_W-1:0] fetch_byte(
      input logic [REG_IDX_W-1:0] idx,
      input logic [BYTE_W-1:0]    even_q,
      input logic [BYTE_W-1:0]    odd_q,
      input logic [REG_COUNT-1:0] valid_bits,
      input logic                 fwd,
      input exec_result_type      last
   );
      logic [BYTE_W-1:0]    val;
      logic [REG_IDX_W-1:0] last_high;
      last_high = {last.dest_index[REG_IDX_W-1:1], 1'b1};
      val = idx[0] ? odd_q : even_q;
      if (!valid_bits[idx]) begin
         val = '0;
      end
      if (fwd) begin
         if ((last.write_kind == WK_BYTE || last.write_kind == WK_PAIR)
             && last.dest_index == idx) begin
            val = last.write_value[BYTE_W-1:0];
         end else if (last.write_kind == WK_PAIR && last_high == idx) begin
            val = last.write_value[WORD_W-1:BYTE_W];
         end
      end
      return val;
   endfunction

   assign operand_a = fetch_byte(idx_a_ff, even_a, odd_a, reg_valid_ff, fwd_ff, rsp_ff);
   assign operand_b = fetch_byte(idx_b_ff, even_b, odd_b, reg_valid_ff, fwd_ff, rsp_ff);

   // execute
   avr8alu_exec u_exec (
      .instruction (ex_instr_ff),
      .operand_a   (operand_a),
      .operand_b   (operand_b),
      .status      (status_ff),
      .result      (ex_result)
   );

   // valid bits of the register file
   always_comb begin
      reg_valid_in = reg_valid_ff;
      if (even_wr_en) begin
         reg_valid_in[{bank_wr_addr, 1'b0}] = 1'b1;
      end
      if (odd_wr_en) begin
         reg_valid_in[{bank_wr_addr, 1'b1}] = 1'b1;
      end
   end

   // status, valid bits and result register
   assign rsp_valid_in = ex_go | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= '0;
         reg_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         reg_valid_ff <= reg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ex_go) begin
            status_ff <= ex_result.status_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ex_go) begin
         rsp_ff <= ex_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.status_after, rsp_ff.write_value, rsp_ff.dest_index};
   assign rsp_tuser  = {rsp_ff.unknown_opcode, rsp_ff.write_kind};

`ifndef ASSERT_OFF
   // an empty result register never blocks the input
   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("req_tready low with result register empty");

   // an unknown opcode leaves the status register untouched
   a_unknown_keeps_status : assert property (@(posedge clock) disable iff (reset)
      ex_go && ex_result.unknown_opcode |=> status_ff == $past(status_ff))
      else $error("unknown opcode changed the status register");

   // an unknown opcode writes nothing
   a_unknown_no_write : assert property (@(posedge clock) disable iff (reset)
      ex_go && ex_result.unknown_opcode |-> !even_wr_en && !odd_wr_en)
      else $error("unknown opcode wrote the register file");

   // pair writes only target r24, r26, r28 or r30
   a_pair_dest : assert property (@(posedge clock) disable iff (reset)
      ex_go && ex_result.write_kind == WK_PAIR
         |-> ex_result.dest_index[0] == 1'b0 && ex_result.dest_index[4:3] == 2'b11)
      else $error("register pair write to a bad index");
`endif

endmodule
